>>> hdl/cfta_pkg.sv
//------------------------------------------------------------------------------
// cfta_pkg: shared types and constants for the contact fabric tensor unit
// Action codes, sequencer states, fixed field widths and a saturating add.
//------------------------------------------------------------------------------
`default_nettype none

package cfta_pkg;

   localparam int DEF_PARTICLES = 1024;
   localparam int IDX_W         = 10;
   localparam int LANES         = 6;
   localparam int LANE_W        = 32;
   localparam int WORD_W        = LANES * LANE_W;
   localparam logic [31:0] GROUP_SEL_RESET = 32'd1;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_PAIR  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_SPARE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR_MEM,
      ST_IDLE,
      ST_ZERO,
      ST_SQUARE,
      ST_CHECK,
      ST_SQRT,
      ST_DIV,
      ST_PROD,
      ST_RD_I,
      ST_WR_I,
      ST_RD_J,
      ST_WR_J,
      ST_RD_OUT,
      ST_OUT
   } state_type;

   // signed 32-bit add that clamps to the 32-bit range
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/contact_fabric_tensor_accumulator_unit.sv
//------------------------------------------------------------------------------
// contact_fabric_tensor_accumulator_unit: per-particle contact fabric tensor
// Iterative sequencer around one shared 32x32 multiplier, a square root unit
// and a restoring divider; six Q16.16 sums per particle kept in one memory.
//------------------------------------------------------------------------------
// Usage:
//  - A transaction is taken when start is high and busy is low. req_action
//    selects clear (zero entry req_index_i), pair (test contact of i and j and
//    add the normal outer product to both entries) or read (the spare code also reads).
//  - Every transaction returns one result: rsp_valid is high for exactly one
//    cycle with entry req_index_i after the action. The receiver cannot stall.
//  - csr_we/csr_wdata write the group select mask at any time the unit idles.
//  - A read passes the memory read and output states; a clear zeroes the
//    entry first; a pair without contact ends after squaring and the check;
//    a pair with contact adds 32 square root steps, 16 divide steps per axis,
//    the product steps and read-modify-write of both entries before output.
//    One transaction at a time; the next may start the cycle after rsp_valid.
//    The square root and divide iterations set the pair rate.
//  - After reset the memory is swept to zero, one entry per cycle, over
//    all PARTICLES entries; busy stays high meanwhile. The mask resets to 1.
//------------------------------------------------------------------------------
`default_nettype none

module contact_fabric_tensor_accumulator_unit #(
   parameter int PARTICLES = cfta_pkg::DEF_PARTICLES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [9:0]  req_index_i,
   input  wire logic [9:0]  req_index_j,
   input  wire logic [31:0] req_pos_i_x,
   input  wire logic [31:0] req_pos_i_y,
   input  wire logic [31:0] req_pos_i_z,
   input  wire logic [31:0] req_pos_j_x,
   input  wire logic [31:0] req_pos_j_y,
   input  wire logic [31:0] req_pos_j_z,
   input  wire logic [30:0] req_radius_i,
   input  wire logic [30:0] req_radius_j,
   input  wire logic [31:0] req_group_bits_i,
   output logic             rsp_valid,
   output logic [9:0]       rsp_entry_index,
   output logic [31:0]      rsp_sum_xx,
   output logic [31:0]      rsp_sum_yy,
   output logic [31:0]      rsp_sum_zz,
   output logic [31:0]      rsp_sum_xy,
   output logic [31:0]      rsp_sum_xz,
   output logic [31:0]      rsp_sum_yz,
   output logic             rsp_in_contact,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);

   localparam int AW = $clog2(PARTICLES);
   localparam int WW = cfta_pkg::WORD_W;

   cfta_pkg::state_type state_ff, state_in;

   // control and datapath registers
   logic [AW-1:0]  clr_ff;
   logic [31:0]    group_sel_ff;
   logic [4:0]     cnt_ff;
   logic [1:0]     axis_ff;
   logic [1:0]     act_ff;
   logic [9:0]     idx_i_ff, idx_j_ff;
   logic           ok_i_ff, ok_j_ff;
   logic [32:0]    mag_ff [3];
   logic [2:0]     neg_ff;
   logic [31:0]    rs_ff;
   logic           far_ff;
   logic [31:0]    grp_ff;
   logic [63:0]    prod_ff;
   logic [65:0]    acc_ff;
   logic [63:0]    lim_ff;
   logic [63:0]    v_ff, res_ff, bit_ff;
   logic [32:0]    rem_ff;
   logic [14:0]    q_ff;
   logic [14:0]    n_ff [3];
   logic [31:0]    t_ff [cfta_pkg::LANES];
   logic           contact_ff;
   logic [WW-1:0]  rd_ff;

   // memory
   logic [WW-1:0]  mem [PARTICLES];
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [WW-1:0]  mem_wdata;

   // combinational helpers
   logic [32:0]    d_c [3];
   logic [32:0]    mag_c [3];
   logic [31:0]    rs_c;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_p;
   logic [63:0]    sq_trial;
   logic           sq_ge;
   logic           div_ge;
   logic [32:0]    div_rem;
   logic [15:0]    q_full;
   logic [2:0]     pk;
   logic [1:0]     pa, pb;
   logic [16:0]    rnd_m;
   logic [31:0]    rnd_t;
   logic           contact_ok;
   logic [WW-1:0]  sum_word;

   // difference, magnitude and radius sum of the incoming pair
   always_comb begin
      d_c[0] = {req_pos_i_x[31], req_pos_i_x} - {req_pos_j_x[31], req_pos_j_x};
      d_c[1] = {req_pos_i_y[31], req_pos_i_y} - {req_pos_j_y[31], req_pos_j_y};
      d_c[2] = {req_pos_i_z[31], req_pos_i_z} - {req_pos_j_z[31], req_pos_j_z};
      for (int k = 0; k < 3; k++) begin
         mag_c[k] = d_c[k][32] ? (33'd0 - d_c[k]) : d_c[k];
      end
      rs_c = {1'b0, req_radius_i} + {1'b0, req_radius_j};
   end

   // product step operands: xx, yy, zz, xy, xz, yz
   always_comb begin
      pk = cnt_ff[2:0] - 3'd1;
      unique case (pk)
         3'd0:    begin pa = 2'd0; pb = 2'd0; end
         3'd1:    begin pa = 2'd1; pb = 2'd1; end
         3'd2:    begin pa = 2'd2; pb = 2'd2; end
         3'd3:    begin pa = 2'd0; pb = 2'd1; end
         3'd4:    begin pa = 2'd0; pb = 2'd2; end
         default: begin pa = 2'd1; pb = 2'd2; end
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      if (state_ff == cfta_pkg::ST_SQUARE) begin
         unique case (cnt_ff[1:0])
            2'd0:    begin mul_a = mag_ff[0][31:0]; mul_b = mag_ff[0][31:0]; end
            2'd1:    begin mul_a = mag_ff[1][31:0]; mul_b = mag_ff[1][31:0]; end
            2'd2:    begin mul_a = mag_ff[2][31:0]; mul_b = mag_ff[2][31:0]; end
            default: begin mul_a = rs_ff;           mul_b = rs_ff;           end
         endcase
      end else if (state_ff == cfta_pkg::ST_PROD) begin
         unique case (cnt_ff[2:0])
            3'd0:    begin mul_a = {17'd0, n_ff[0]}; mul_b = {17'd0, n_ff[0]}; end
            3'd1:    begin mul_a = {17'd0, n_ff[1]}; mul_b = {17'd0, n_ff[1]}; end
            3'd2:    begin mul_a = {17'd0, n_ff[2]}; mul_b = {17'd0, n_ff[2]}; end
            3'd3:    begin mul_a = {17'd0, n_ff[0]}; mul_b = {17'd0, n_ff[1]}; end
            3'd4:    begin mul_a = {17'd0, n_ff[0]}; mul_b = {17'd0, n_ff[2]}; end
            default: begin mul_a = {17'd0, n_ff[1]}; mul_b = {17'd0, n_ff[2]}; end
         endcase
      end
      mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   end

   // square root step, divide step, product rounding
   always_comb begin
      sq_trial = res_ff + bit_ff;
      sq_ge    = (v_ff >= sq_trial);
      div_ge   = (rem_ff >= {1'b0, res_ff[31:0]});
      div_rem  = div_ge ? (rem_ff - {1'b0, res_ff[31:0]}) : rem_ff;
      q_full   = {q_ff, div_ge};
      rnd_m    = 17'((prod_ff[29:0] + 30'd8192) >> 14);
      rnd_t    = (neg_ff[pa] ^ neg_ff[pb]) ? (32'd0 - {15'd0, rnd_m}) : {15'd0, rnd_m};
      contact_ok = ((grp_ff & group_sel_ff) != 32'd0) && !far_ff &&
                   (acc_ff[65:64] == 2'd0) && (acc_ff != 66'd0) &&
                   (acc_ff[63:0] <= lim_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfta_pkg::ST_CLEAR_MEM: if (clr_ff == AW'(PARTICLES - 1)) state_in = cfta_pkg::ST_IDLE;
         cfta_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_action)
                  cfta_pkg::ACT_CLEAR: state_in = cfta_pkg::ST_ZERO;
                  cfta_pkg::ACT_PAIR:  state_in = cfta_pkg::ST_SQUARE;
                  default:             state_in = cfta_pkg::ST_RD_OUT;
               endcase
            end
         end
         cfta_pkg::ST_ZERO:   state_in = cfta_pkg::ST_RD_OUT;
         cfta_pkg::ST_SQUARE: if (cnt_ff == 5'd4) state_in = cfta_pkg::ST_CHECK;
         cfta_pkg::ST_CHECK:
            state_in = contact_ok ? cfta_pkg::ST_SQRT : cfta_pkg::ST_RD_OUT;
         cfta_pkg::ST_SQRT:   if (cnt_ff == 5'd31) state_in = cfta_pkg::ST_DIV;
         cfta_pkg::ST_DIV:
            if (cnt_ff == 5'd15 && axis_ff == 2'd2) state_in = cfta_pkg::ST_PROD;
         cfta_pkg::ST_PROD:   if (cnt_ff == 5'd6) state_in = cfta_pkg::ST_RD_I;
         cfta_pkg::ST_RD_I:   state_in = cfta_pkg::ST_WR_I;
         cfta_pkg::ST_WR_I:   state_in = cfta_pkg::ST_RD_J;
         cfta_pkg::ST_RD_J:   state_in = cfta_pkg::ST_WR_J;
         cfta_pkg::ST_WR_J:   state_in = cfta_pkg::ST_RD_OUT;
         cfta_pkg::ST_RD_OUT: state_in = cfta_pkg::ST_OUT;
         cfta_pkg::ST_OUT:    state_in = cfta_pkg::ST_IDLE;
         default:             state_in = cfta_pkg::ST_IDLE;
      endcase
   end

   // sum of current read word and contact tensor, lane by lane
   always_comb begin
      for (int k = 0; k < cfta_pkg::LANES; k++) begin
         sum_word[k*32 +: 32] = cfta_pkg::sat_add(rd_ff[k*32 +: 32], t_ff[k]);
      end
   end

   // memory port control and outputs
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(idx_i_ff);
      mem_wdata = '0;
      mem_raddr = AW'(idx_i_ff);
      rsp_valid = 1'b0;
      busy      = 1'b1;
      unique case (state_ff)
         cfta_pkg::ST_CLEAR_MEM: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         cfta_pkg::ST_IDLE: busy = 1'b0;
         cfta_pkg::ST_ZERO: mem_we = ok_i_ff;
         cfta_pkg::ST_WR_I: begin
            mem_we    = ok_i_ff;
            mem_wdata = sum_word;
         end
         cfta_pkg::ST_RD_J: mem_raddr = AW'(idx_j_ff);
         cfta_pkg::ST_WR_J: begin
            mem_we    = ok_j_ff;
            mem_waddr = AW'(idx_j_ff);
            mem_wdata = sum_word;
         end
         cfta_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_entry_index = idx_i_ff;
   assign rsp_sum_xx      = ok_i_ff ? rd_ff[0*32 +: 32] : 32'd0;
   assign rsp_sum_yy      = ok_i_ff ? rd_ff[1*32 +: 32] : 32'd0;
   assign rsp_sum_zz      = ok_i_ff ? rd_ff[2*32 +: 32] : 32'd0;
   assign rsp_sum_xy      = ok_i_ff ? rd_ff[3*32 +: 32] : 32'd0;
   assign rsp_sum_xz      = ok_i_ff ? rd_ff[4*32 +: 32] : 32'd0;
   assign rsp_sum_yz      = ok_i_ff ? rd_ff[5*32 +: 32] : 32'd0;
   assign rsp_in_contact  = rsp_valid & contact_ff & (act_ff == cfta_pkg::ACT_PAIR);

   // tensor memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfta_pkg::ST_CLEAR_MEM;
         clr_ff       <= '0;
         group_sel_ff <= cfta_pkg::GROUP_SEL_RESET;
         cnt_ff       <= 5'd0;
         axis_ff      <= 2'd0;
         contact_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            group_sel_ff <= csr_wdata;
         end
         if (state_ff == cfta_pkg::ST_CLEAR_MEM) begin
            clr_ff <= clr_ff + AW'(1);
         end
         // step counter restarts on a state change and for each divide axis
         if (state_in != state_ff ||
             (state_ff == cfta_pkg::ST_DIV && cnt_ff == 5'd15)) begin
            cnt_ff <= 5'd0;
         end else begin
            cnt_ff <= cnt_ff + 5'd1;
         end
         if (state_ff == cfta_pkg::ST_IDLE) begin
            contact_ff <= 1'b0;
            axis_ff    <= 2'd0;
         end
         if (state_ff == cfta_pkg::ST_CHECK) begin
            contact_ff <= contact_ok;
         end
         if (state_ff == cfta_pkg::ST_DIV && cnt_ff == 5'd15) begin
            axis_ff <= axis_ff + 2'd1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      unique case (state_ff)
         cfta_pkg::ST_IDLE: begin
            act_ff   <= req_action;
            idx_i_ff <= req_index_i;
            idx_j_ff <= req_index_j;
            ok_i_ff  <= ({22'd0, req_index_i} < 32'(PARTICLES));
            ok_j_ff  <= ({22'd0, req_index_j} < 32'(PARTICLES));
            for (int k = 0; k < 3; k++) begin
               mag_ff[k] <= mag_c[k];
               neg_ff[k] <= d_c[k][32];
            end
            rs_ff  <= rs_c;
            far_ff <= (mag_c[0] > {1'b0, rs_c}) || (mag_c[1] > {1'b0, rs_c}) ||
                      (mag_c[2] > {1'b0, rs_c});
            grp_ff <= req_group_bits_i;
            acc_ff <= 66'd0;
         end
         cfta_pkg::ST_SQUARE: begin
            if (cnt_ff == 5'd4) begin
               lim_ff <= prod_ff;
            end else if (cnt_ff != 5'd0) begin
               acc_ff <= acc_ff + {2'd0, prod_ff};
            end
         end
         cfta_pkg::ST_CHECK: begin
            v_ff   <= acc_ff[63:0];
            res_ff <= 64'd0;
            bit_ff <= 64'd1 << 62;
         end
         cfta_pkg::ST_SQRT: begin
            if (sq_ge) begin
               v_ff   <= v_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            rem_ff <= mag_ff[0];
         end
         cfta_pkg::ST_DIV: begin
            q_ff <= q_full[14:0];
            if (cnt_ff == 5'd15) begin
               n_ff[axis_ff] <= q_full[15] ? 15'h7FFF : q_full[14:0];
               if (axis_ff != 2'd2) begin
                  rem_ff <= mag_ff[axis_ff + 2'd1];
               end
            end else begin
               rem_ff <= {div_rem[31:0], 1'b0};
            end
         end
         cfta_pkg::ST_PROD: begin
            if (cnt_ff != 5'd0) begin
               t_ff[pk] <= rnd_t;
            end
         end
         default: ;
      endcase
   end

   // assertions
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a transaction");

   a_contact_only_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_in_contact |-> (rsp_valid && act_ff == cfta_pkg::ACT_PAIR))
      else $error("contact flag outside a pair result");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfta_pkg::ST_IDLE) |-> !mem_we)
      else $error("memory written while idle");

endmodule

`default_nettype wire

>>> verif/contact_fabric_tensor_accumulator_unit_tb.sv
//------------------------------------------------------------------------------
// contact_fabric_tensor_accumulator_unit_tb: self-checking bench for the unit
// A queue of pending transactions feeds a clocked driver. A clocked monitor
// compares each result with the predicted fabric tensor entry. The predictor
// keeps its own six sum arrays and its own copy of the group mask.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module contact_fabric_tensor_accumulator_unit_tb;

   localparam int NPART = cfta_pkg::DEF_PARTICLES;
   localparam int LANES = cfta_pkg::LANES;

   typedef struct {
      cfta_pkg::action_type act;
      logic [9:0]  idx_i;
      logic [9:0]  idx_j;
      logic [31:0] pix, piy, piz, pjx, pjy, pjz;
      logic [30:0] rad_i, rad_j;
      logic [31:0] grp;
   } pair_req_type;

   typedef struct {
      logic [9:0]  entry;
      logic [31:0] sums [LANES];
      logic        contact;
   } tensor_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_action = '0;
   logic [9:0]  req_index_i = '0, req_index_j = '0;
   logic [31:0] req_pos_i_x = '0, req_pos_i_y = '0, req_pos_i_z = '0;
   logic [31:0] req_pos_j_x = '0, req_pos_j_y = '0, req_pos_j_z = '0;
   logic [30:0] req_radius_i = '0, req_radius_j = '0;
   logic [31:0] req_group_bits_i = '0;
   logic        rsp_valid;
   logic [9:0]  rsp_entry_index;
   logic [31:0] rsp_sum_xx, rsp_sum_yy, rsp_sum_zz, rsp_sum_xy, rsp_sum_xz, rsp_sum_yz;
   logic        rsp_in_contact;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   contact_fabric_tensor_accumulator_unit i_dut (.*);

   // predictor state
   logic [31:0] fabric [LANES][NPART];
   logic [31:0] mask_model;

   pair_req_type   pending_reqs [$];
   tensor_rsp_type expected_tensors [$];
   int          error_count = 0;
   int          sent_count = 0, result_count = 0, contact_count = 0;
   int          idle_pct = 0;
   logic        driving = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // integer square root, bit by bit
   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic longint normal_comp(input longint d, input logic [63:0] r);
      logic [63:0] q, m;
      m = (d < 0) ? -d : d;
      q = (m << 15) / r;
      if (q > 32767) q = 32767;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Q2.30 product rounded to Q16.16, ties away from zero
   function automatic logic [31:0] round_prod(input longint a, input longint b);
      longint p, m;
      p = a * b;
      m = (((p < 0) ? -p : p) + 8192) >>> 14;
      return (p < 0) ? 32'(-m) : 32'(m);
   endfunction

   function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
      longint s;
      s = longint'($signed(a)) + longint'($signed(b));
      if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
      if (s < -64'sh8000_0000) s = -64'sh8000_0000;
      return 32'(s);
   endfunction

   // contact test and normal outer product; returns 0 for no contact
   function automatic bit contact_tensor(input pair_req_type t,
                                         output logic [31:0] dt [LANES]);
      longint dx, dy, dz, nx, ny, nz;
      logic [63:0] ax, ay, az, rs, lim, acc, sq, r;
      dx = longint'($signed(t.pix)) - longint'($signed(t.pjx));
      dy = longint'($signed(t.piy)) - longint'($signed(t.pjy));
      dz = longint'($signed(t.piz)) - longint'($signed(t.pjz));
      rs = 64'(t.rad_i) + 64'(t.rad_j);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      foreach (dt[k]) dt[k] = '0;
      if (ax > rs || ay > rs || az > rs) return 0;
      lim = rs * rs;
      acc = ax * ax;
      sq = ay * ay;
      if (acc + sq < acc) return 0;
      acc += sq;
      sq = az * az;
      if (acc + sq < acc) return 0;
      acc += sq;
      if (acc == 0 || acc > lim) return 0;
      r = root64(acc);
      nx = normal_comp(dx, r);
      ny = normal_comp(dy, r);
      nz = normal_comp(dz, r);
      dt[0] = round_prod(nx, nx);
      dt[1] = round_prod(ny, ny);
      dt[2] = round_prod(nz, nz);
      dt[3] = round_prod(nx, ny);
      dt[4] = round_prod(nx, nz);
      dt[5] = round_prod(ny, nz);
      return 1;
   endfunction

   // advance the fabric model by one transaction and queue its result
   task automatic predict_fabric(input pair_req_type t);
      tensor_rsp_type e;
      logic [31:0] dt [LANES];
      e.contact = 1'b0;
      if (t.act == cfta_pkg::ACT_CLEAR) begin
         for (int k = 0; k < LANES; k++) fabric[k][t.idx_i] = '0;
      end else if (t.act == cfta_pkg::ACT_PAIR) begin
         if ((t.grp & mask_model) != 0 && contact_tensor(t, dt)) begin
            e.contact = 1'b1;
            for (int k = 0; k < LANES; k++) begin
               fabric[k][t.idx_i] = clamp_add(fabric[k][t.idx_i], dt[k]);
               fabric[k][t.idx_j] = clamp_add(fabric[k][t.idx_j], dt[k]);
            end
         end
      end
      e.entry = t.idx_i;
      for (int k = 0; k < LANES; k++) e.sums[k] = fabric[k][t.idx_i];
      expected_tensors.push_back(e);
   endtask

   // driver: one transaction at a time, random gaps while a phase asks for them
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predict_fabric(pending_reqs.pop_front());
            sent_count++;
         end
         if (driving && pending_reqs.size() > 0 &&
             !(start && !busy && pending_reqs.size() == 0) &&
             $urandom_range(99) >= idle_pct) begin
            start            <= 1'b1;
            req_action       <= pending_reqs[0].act;
            req_index_i      <= pending_reqs[0].idx_i;
            req_index_j      <= pending_reqs[0].idx_j;
            req_pos_i_x      <= pending_reqs[0].pix;
            req_pos_i_y      <= pending_reqs[0].piy;
            req_pos_i_z      <= pending_reqs[0].piz;
            req_pos_j_x      <= pending_reqs[0].pjx;
            req_pos_j_y      <= pending_reqs[0].pjy;
            req_pos_j_z      <= pending_reqs[0].pjz;
            req_radius_i     <= pending_reqs[0].rad_i;
            req_radius_j     <= pending_reqs[0].rad_j;
            req_group_bits_i <= pending_reqs[0].grp;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result against the oldest prediction
   always @(posedge clock) begin
      tensor_rsp_type e;
      logic [31:0] got [LANES];
      if (!reset && rsp_valid) begin
         result_count++;
         if (rsp_in_contact) contact_count++;
         if (expected_tensors.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_entry_index), '0);
         end else begin
            e = expected_tensors.pop_front();
            got = '{rsp_sum_xx, rsp_sum_yy, rsp_sum_zz, rsp_sum_xy, rsp_sum_xz, rsp_sum_yz};
            if (rsp_entry_index !== e.entry)
               report_mismatch("entry_index", 32'(rsp_entry_index), 32'(e.entry));
            for (int k = 0; k < LANES; k++)
               if (got[k] !== e.sums[k])
                  report_mismatch($sformatf("sum lane %0d entry %0d", k, e.entry),
                                  got[k], e.sums[k]);
            if (rsp_in_contact !== e.contact)
               report_mismatch("in_contact", 32'(rsp_in_contact), 32'(e.contact));
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'h8000_0000 ^ $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         default: return 32'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   // mostly touching pairs on a small set of entries, some noise
   function automatic pair_req_type rand_req();
      pair_req_type t;
      int unsigned spread;
      t.act   = cfta_pkg::action_type'($urandom_range(9) < 6 ? cfta_pkg::ACT_PAIR
                                                              : $urandom_range(3));
      t.idx_i = ($urandom_range(9) == 0) ? 10'($urandom()) : 10'($urandom_range(15));
      t.idx_j = ($urandom_range(9) == 0) ? 10'($urandom()) : 10'($urandom_range(15));
      t.grp   = ($urandom_range(4) == 0) ? $urandom() : ($urandom() | 32'h1);
      if ($urandom_range(4) == 0) begin
         t.pix = rand_word(); t.piy = rand_word(); t.piz = rand_word();
         t.pjx = rand_word(); t.pjy = rand_word(); t.pjz = rand_word();
         t.rad_i = 31'($urandom()); t.rad_j = 31'($urandom());
      end else begin
         spread = 1 << $urandom_range(22, 4);
         t.pix = $urandom(); t.piy = $urandom(); t.piz = $urandom();
         t.pjx = t.pix + $urandom_range(spread) - spread / 2;
         t.pjy = t.piy + $urandom_range(spread) - spread / 2;
         t.pjz = t.piz + $urandom_range(spread) - spread / 2;
         t.rad_i = 31'($urandom_range(spread));
         t.rad_j = 31'($urandom_range(spread));
      end
      return t;
   endfunction

   function automatic pair_req_type make_pair(input logic [9:0] ii, input logic [9:0] jj,
                                              input logic [31:0] dx, input logic [31:0] dy,
                                              input logic [31:0] dz, input logic [30:0] rr);
      pair_req_type t;
      t = '{cfta_pkg::ACT_PAIR, ii, jj, dx, dy, dz, '0, '0, '0, rr, rr, 32'h1};
      return t;
   endfunction

   task automatic run_phase(input int pct, input int count);
      idle_pct = pct;
      for (int n = 0; n < count; n++) pending_reqs.push_back(rand_req());
      driving = 1'b1;
      wait (pending_reqs.size() == 0 && expected_tensors.size() == 0);
      @(posedge clock);
      driving = 1'b0;
      repeat (120) @(posedge clock);
   endtask

   task automatic write_mask(input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      mask_model = v;
   endtask

   initial begin
      pair_req_type t;
      foreach (fabric[k, e]) fabric[k][e] = '0;
      mask_model = cfta_pkg::GROUP_SEL_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: clear, read, spare code, touching axis pairs, coincident
      // centers, self pair, unselected group, extreme positions and radii
      pending_reqs.push_back(make_pair(10'd0, 10'd1, 32'h0001_0000, '0, '0, 31'h0001_0000));
      pending_reqs.push_back(make_pair(10'd0, 10'd2, '0, 32'hFFFF_0000, '0, 31'h0001_0000));
      pending_reqs.push_back(make_pair(10'd1, 10'd2, 32'h1, 32'h1, 32'h1, 31'h1));
      pending_reqs.push_back(make_pair(10'd3, 10'd3, '0, '0, '0, 31'h7FFF_FFFF));
      pending_reqs.push_back(make_pair(10'd1023, 10'd1022, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 31'h7FFF_FFFF));
      pending_reqs.push_back(make_pair(10'd5, 10'd6, 32'h8000_0000, '0, '0, 31'h4000_0000));
      t = make_pair(10'd0, 10'd1, 32'h0001_0000, '0, '0, 31'h0001_0000);
      t.grp = 32'hFFFF_FFFE;
      pending_reqs.push_back(t);
      t.act = cfta_pkg::ACT_READ;
      pending_reqs.push_back(t);
      t.act = cfta_pkg::ACT_SPARE;
      t.idx_i = 10'd1023;
      pending_reqs.push_back(t);
      t.act = cfta_pkg::ACT_CLEAR;
      t.idx_i = 10'd0;
      pending_reqs.push_back(t);
      t.act = cfta_pkg::ACT_READ;
      pending_reqs.push_back(t);
      // repeated x-axis contacts accumulating into entries 7 and 8
      for (int n = 0; n < 8; n++)
         pending_reqs.push_back(make_pair(10'd7, 10'd8, 32'h7FFF_FFFF, '0, '0,
                                          31'h7FFF_FFFF));
      run_phase(0, 0);

      write_mask(32'hFFFF_FFFF);
      run_phase(0, 250);
      write_mask(32'h0000_0000);
      run_phase(61, 60);
      write_mask(32'h8000_0000);
      run_phase(0, 200);
      write_mask($urandom());
      run_phase(20, 200);
      write_mask(32'h0000_0001);
      run_phase(0, 140);

      $display("Covered %0d transactions, %0d results, %0d counted contacts,",
               sent_count, result_count, contact_count);
      $display("over several group masks and sender gap rates.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Timeout waiting for results");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
hdl/cfta_pkg.sv
hdl/contact_fabric_tensor_accumulator_unit.sv
verif/contact_fabric_tensor_accumulator_unit_tb.sv
